// ===== sv/rmsd_pkg.sv =====
package rmsd_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_W       = 16;

  localparam int SUM_W  = COUNT_BITS + SAMPLE_BITS;
  localparam int SQ_W   = COUNT_BITS + 2 * SAMPLE_BITS;
  localparam int ROOT_W = (SQ_W + 1) / 2;

  localparam int MEAN_STEPS = SUM_W;
  localparam int MUL_STEPS  = SAMPLE_BITS;
  localparam int VAR_STEPS  = SQ_W;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int CNT_W      = $clog2(VAR_STEPS + 1);

  localparam int OUT_MAX = (1 << OUT_W) - 1;

  typedef struct packed {
    logic capture;
    logic accum;
    logic mean_load;
    logic div_step;
    logic mul_load;
    logic mul_step;
    logic var_load;
    logic sqrt_load;
    logic sqrt_step;
    logic stats_load;
    logic out_load;
    logic out_updated;
  } cmd_t;

  typedef struct packed {
    logic count_full;
    logic count_zero;
  } status_t;

endpackage

// ===== sv/rmsd_ctrl.sv =====
module rmsd_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  rmsd_pkg::status_t status,
  output rmsd_pkg::cmd_t   cmd
);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b0000_0000_0001,
    ST_ACCUM     = 12'b0000_0000_0010,
    ST_MEAN_LOAD = 12'b0000_0000_0100,
    ST_MEAN_DIV  = 12'b0000_0000_1000,
    ST_MUL_LOAD  = 12'b0000_0001_0000,
    ST_MUL       = 12'b0000_0010_0000,
    ST_VAR_LOAD  = 12'b0000_0100_0000,
    ST_VAR_DIV   = 12'b0000_1000_0000,
    ST_SQRT_LOAD = 12'b0001_0000_0000,
    ST_SQRT      = 12'b0010_0000_0000,
    ST_STORE     = 12'b0100_0000_0000,
    ST_WRITE     = 12'b1000_0000_0000
  } state_t;

  state_t                      state, state_next;
  logic [rmsd_pkg::CNT_W-1:0]  cnt, cnt_next;
  logic                        updated, updated_next;
  logic                        out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    updated_next   = updated;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture  = 1'b1;
          updated_next = 1'b0;
          state_next   = status.count_full ? ST_WRITE : ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        cmd.accum  = 1'b1;
        state_next = status.count_zero ? ST_WRITE : ST_MEAN_LOAD;
      end
      ST_MEAN_LOAD: begin
        cmd.mean_load = 1'b1;
        cnt_next      = rmsd_pkg::CNT_W'(rmsd_pkg::MEAN_STEPS);
        state_next    = ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == rmsd_pkg::CNT_W'(1)) state_next = ST_MUL_LOAD;
      end
      ST_MUL_LOAD: begin
        cmd.mul_load = 1'b1;
        cnt_next     = rmsd_pkg::CNT_W'(rmsd_pkg::MUL_STEPS);
        state_next   = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == rmsd_pkg::CNT_W'(1)) state_next = ST_VAR_LOAD;
      end
      ST_VAR_LOAD: begin
        cmd.var_load = 1'b1;
        cnt_next     = rmsd_pkg::CNT_W'(rmsd_pkg::VAR_STEPS);
        state_next   = ST_VAR_DIV;
      end
      ST_VAR_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt - 1'b1;
        if (cnt == rmsd_pkg::CNT_W'(1)) state_next = ST_SQRT_LOAD;
      end
      ST_SQRT_LOAD: begin
        cmd.sqrt_load = 1'b1;
        cnt_next      = rmsd_pkg::CNT_W'(rmsd_pkg::ROOT_STEPS);
        state_next    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_next      = cnt - 1'b1;
        if (cnt == rmsd_pkg::CNT_W'(1)) state_next = ST_STORE;
      end
      ST_STORE: begin
        cmd.stats_load = 1'b1;
        updated_next   = 1'b1;
        state_next     = ST_WRITE;
      end
      ST_WRITE: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.out_load    = 1'b1;
          cmd.out_updated = updated;
          out_valid_next  = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      updated   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      updated   <= updated_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/rmsd_datapath.sv =====
module rmsd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rmsd_pkg::cmd_t                cmd,
  output rmsd_pkg::status_t             status,
  input  logic [15:0]                   lag_ms,
  output logic [rmsd_pkg::OUT_W-1:0]    mean_ms,
  output logic [rmsd_pkg::OUT_W-1:0]    stddev_ms,
  output logic                          stats_updated
);

  localparam int CB = rmsd_pkg::COUNT_BITS;
  localparam int SB = rmsd_pkg::SAMPLE_BITS;
  localparam int SW = rmsd_pkg::SUM_W;
  localparam int QW = rmsd_pkg::SQ_W;
  localparam int RW = rmsd_pkg::ROOT_W;

  // architectural state
  logic [CB-1:0]              sample_count;
  logic [SW-1:0]              sample_sum;
  logic [QW-1:0]              square_sum;
  logic [SB-1:0]              mean_value;
  logic [rmsd_pkg::OUT_W-1:0] deviation_value;

  // working registers
  logic [SB-1:0]   sample;
  logic [2*SB-1:0] sample_sq;
  logic [CB-1:0]   div_den;
  logic [CB-1:0]   div_rem;
  logic [QW-1:0]   div_dq;
  logic [SB-1:0]   mean_q;
  logic [SB-1:0]   mul_m;
  logic [QW-1:0]   mul_acc;
  logic [2*RW-1:0] sq_rad;
  logic [RW:0]     sq_rem;
  logic [RW-1:0]   sq_root;

  logic [CB:0]   div_trial;
  logic          div_bit;
  logic [QW-1:0] mul_add;
  logic [RW+2:0] sq_t;
  logic [RW+2:0] sq_trial;
  logic          sq_bit;
  logic [RW+2:0] sq_diff;

  assign status.count_full = (sample_count == {CB{1'b1}});
  assign status.count_zero = (sample_count == '0);

  assign div_trial = {div_rem, div_dq[QW-1]};
  assign div_bit   = (div_trial >= {1'b0, div_den});

  assign mul_add = mul_m[SB-1] ? QW'(sample_sum) : '0;

  assign sq_t     = {sq_rem, sq_rad[2*RW-1 -: 2]};
  assign sq_trial = {1'b0, sq_root, 2'b01};
  assign sq_bit   = (sq_t >= sq_trial);
  assign sq_diff  = sq_t - sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      sample_sum      <= '0;
      square_sum      <= '0;
      mean_value      <= '0;
      deviation_value <= '0;
    end else begin
      if (cmd.accum) begin
        sample_count <= sample_count + 1'b1;
        sample_sum   <= sample_sum + SW'(sample);
        square_sum   <= square_sum + QW'(sample_sq);
      end
      if (cmd.stats_load) begin
        mean_value <= mean_q;
        if (33'(sq_root) > 33'(rmsd_pkg::OUT_MAX)) begin
          deviation_value <= rmsd_pkg::OUT_W'(rmsd_pkg::OUT_MAX);
        end else begin
          deviation_value <= rmsd_pkg::OUT_W'(sq_root);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample    <= lag_ms[SB-1:0];
      sample_sq <= lag_ms[SB-1:0] * lag_ms[SB-1:0];
    end

    // shared restoring divider: dividend out at the top, quotient in at the bottom
    if (cmd.mean_load) begin
      div_den <= sample_count;
      div_rem <= '0;
      div_dq  <= {sample_sum, {SB{1'b0}}};
    end else if (cmd.var_load) begin
      div_den <= sample_count - 1'b1;
      div_rem <= '0;
      div_dq  <= square_sum - mul_acc;
    end else if (cmd.div_step) begin
      div_rem <= div_bit ? CB'(div_trial - {1'b0, div_den}) : div_trial[CB-1:0];
      div_dq  <= {div_dq[QW-2:0], div_bit};
    end

    // shift-add multiply of the mean by the running sum
    if (cmd.mul_load) begin
      mean_q  <= div_dq[SB-1:0];
      mul_m   <= div_dq[SB-1:0];
      mul_acc <= '0;
    end else if (cmd.mul_step) begin
      mul_acc <= {mul_acc[QW-2:0], 1'b0} + mul_add;
      mul_m   <= {mul_m[SB-2:0], 1'b0};
    end

    // digit-by-digit floor square root, two radicand bits a step
    if (cmd.sqrt_load) begin
      sq_rad  <= (2*RW)'(div_dq);
      sq_rem  <= '0;
      sq_root <= '0;
    end else if (cmd.sqrt_step) begin
      sq_rad  <= {sq_rad[2*RW-3:0], 2'b00};
      sq_rem  <= sq_bit ? sq_diff[RW:0] : sq_t[RW:0];
      sq_root <= {sq_root[RW-2:0], sq_bit};
    end

    if (cmd.out_load) begin
      mean_ms       <= rmsd_pkg::OUT_W'(mean_value);
      stddev_ms     <= deviation_value;
      stats_updated <= cmd.out_updated;
    end
  end

endmodule

// ===== sv/running_mean_stddev_unit.sv =====
// Running mean and sample standard deviation of latency samples.
//
// Input channel: in_valid / in_stall carry one lag_ms word per item.
// Output channel: out_valid / out_stall carry one result word per item:
// mean_ms, stddev_ms and stats_updated.
//
// Throughput: one item at a time; the input is taken only while the
// controller is idle. When the statistics are recomputed, an accepted
// word passes through accumulate, a load and a 36-step divide for the
// mean, a load and a 16-step shift-add multiply, a load and a 52-step
// divide for the variance, a load and a 26-step square root, store and
// write; the first sample goes from accumulate straight to write, and a
// word that arrives once the count is full goes straight to write.
//
// Reset (rst, synchronous) clears the count, both sums and the held
// mean and deviation, and drops any pending output word.
// When the receiver stalls, the output register holds its word; a new
// input word may still be taken, and its result waits until the
// register is free.
module running_mean_stddev_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [15:0]                lag_ms,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rmsd_pkg::OUT_W-1:0] mean_ms,
  output logic [rmsd_pkg::OUT_W-1:0] stddev_ms,
  output logic                       stats_updated
);

  rmsd_pkg::cmd_t    cmd;
  rmsd_pkg::status_t status;

  // sequence the accumulate, divide, multiply and root steps
  rmsd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // hold the statistics state and the shared serial arithmetic
  rmsd_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .lag_ms        (lag_ms),
    .mean_ms       (mean_ms),
    .stddev_ms     (stddev_ms),
    .stats_updated (stats_updated)
  );

endmodule

// ===== sv/rmsd_checker.sv =====
module rmsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] mean_ms,
  input logic [15:0] stddev_ms,
  input logic        stats_updated
);

  // one word in flight: the input closes right after an accept
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a word is in flight");

  // no result can appear in the cycle straight after an accept
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result raised too early after accept");

  // reset drops any pending output word
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !out_valid)
    else $error("output valid straight after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(mean_ms) && $stable(stddev_ms) && $stable(stats_updated)))
    else $error("stalled output word changed");

endmodule

bind running_mean_stddev_unit rmsd_checker u_rmsd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .mean_ms       (mean_ms),
  .stddev_ms     (stddev_ms),
  .stats_updated (stats_updated)
);
